FILE: hdl/crahf_pkg.sv
// Package for the RSSI gate and amplitude-history filter.
// Shared constants, configuration register indexes and the frame and result words.
// Depends on nothing.
package crahf_pkg;

  // Default sizes of the block
  localparam int SUBCARRIERS_DEF    = 64;
  localparam int HISTORY_ROWS_DEF   = 10;
  localparam int AMPLITUDE_BITS_DEF = 16;

  // Fixed field widths
  localparam int ITEM_W      = 16;
  localparam int COUNT_W     = 32;
  localparam int PERMILLE_W  = 10;
  localparam int RSSI_W      = 8;
  localparam int CFG_INDEX_W = 1;

  localparam logic [ITEM_W-1:0]     ITEM_MAX     = 16'hFFFF;
  localparam logic [PERMILLE_W-1:0] PERMILLE_MAX = 10'd1000;

  // Deviation test scale: 1000 per mille times the quarter-LSB epsilon
  localparam int              SCALE_W  = 12;
  localparam logic [SCALE_W-1:0] SCALE_X4 = 12'd4000;

  // Rows summed per adder-tree leaf group
  localparam int GROUP_ROWS = 4;

  // Result queue depth, also the number of frames allowed in flight
  localparam int RESULT_FIFO_DEPTH = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMP_ENABLE = 1'b1;

  // Per-frame facts carried alongside the deviation test
  typedef struct packed {
    logic                  amp;
    logic [PERMILLE_W-1:0] permille;
    logic                  passed;
    logic                  valid_in;
    logic [COUNT_W-1:0]    processed;
    logic [COUNT_W-1:0]    passed_n;
    logic [COUNT_W-1:0]    filtered;
  } frame_meta_t;

  // One result word
  typedef struct packed {
    logic               passed;
    logic               valid_out;
    logic [COUNT_W-1:0] processed;
    logic [COUNT_W-1:0] passed_n;
    logic [COUNT_W-1:0] filtered;
  } result_t;

endpackage

FILE: hdl/crahf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old contents.
// Depends on nothing.
module crahf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/crahf_change.sv
// Amplitude change test: mean of nonzero history rows against the frame mean.
// Fully pipelined with no stall, one frame per cycle.
// Depends on crahf_pkg.
module crahf_change #(
  parameter int SUBCARRIERS    = crahf_pkg::SUBCARRIERS_DEF,
  parameter int HISTORY_ROWS   = crahf_pkg::HISTORY_ROWS_DEF,
  parameter int AMPLITUDE_BITS = crahf_pkg::AMPLITUDE_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                start,
  input  logic [AMPLITUDE_BITS+$clog2(SUBCARRIERS)-1:0]       sums [HISTORY_ROWS],
  input  logic [AMPLITUDE_BITS+crahf_pkg::ITEM_W-1:0]         frame_sum,
  input  logic [crahf_pkg::ITEM_W-1:0]                        frame_count,
  input  crahf_pkg::frame_meta_t                              meta,
  output logic                                                res_valid,
  output crahf_pkg::result_t                                  res
);
  import crahf_pkg::*;

  localparam int RSW = AMPLITUDE_BITS + $clog2(SUBCARRIERS);
  localparam int SW  = AMPLITUDE_BITS + ITEM_W;
  localparam int NG  = (HISTORY_ROWS + GROUP_ROWS - 1) / GROUP_ROWS;
  localparam int NP  = NG * GROUP_ROWS;
  localparam int GW  = RSW + 2;
  localparam int HW  = RSW + 4;
  localparam int VW  = $clog2(HISTORY_ROWS + 1);
  localparam int WW  = SW + VW + 1;
  localparam int LW  = WW + SCALE_W;

  logic [RSW-1:0] sums_pad [NP];

  // Stage valids
  logic e1_v, e2_v, e3_v, e4_v, e5_v, e6_v;

  logic [RSW-1:0]    e1_sums [NP];
  logic [SW-1:0]     e1_s, e2_s, e3_s;
  logic [ITEM_W-1:0] e1_n, e2_n, e3_n;
  frame_meta_t       e1_meta, e2_meta, e3_meta, e4_meta, e5_meta, e6_meta;

  logic [GW-1:0] gsum_c [NG];
  logic [2:0]    gcnt_c [NG];
  logic [GW-1:0] e2_gsum [NG];
  logic [2:0]    e2_gcnt [NG];

  logic [HW-1:0] h_c, e3_h, e4_h;
  logic [VW-1:0] v_c, e3_v_cnt;

  logic [WW-1:0] s_ext, n_ext, e4_sv, e4_nv;
  logic [WW-1:0] hh, diff_c, rhsa_c, e5_diff, e5_rhsa;
  logic [LW-1:0] e6_lhs, e6_rhs;

  // Pad the row sums up to whole leaf groups
  for (genvar r = 0; r < NP; r++) begin : g_pad
    if (r < HISTORY_ROWS) begin : g_row
      assign sums_pad[r] = sums[r];
    end else begin : g_zero
      assign sums_pad[r] = '0;
    end
  end

  // Leaf groups: sum and count the nonzero rows
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gsum_c[g] = '0;
      gcnt_c[g] = '0;
      for (int k = 0; k < GROUP_ROWS; k++) begin
        if (e1_sums[g*GROUP_ROWS+k] != '0) begin
          gsum_c[g] = gsum_c[g] + GW'(e1_sums[g*GROUP_ROWS+k]);
          gcnt_c[g] = gcnt_c[g] + 3'd1;
        end
      end
    end
  end

  // Root of the tree: history total and nonzero row count
  always_comb begin
    h_c = '0;
    v_c = '0;
    for (int g = 0; g < NG; g++) begin
      h_c = h_c + HW'(e2_gsum[g]);
      v_c = v_c + VW'(e2_gcnt[g]);
    end
  end

  assign s_ext = WW'(e3_s);
  assign n_ext = WW'(e3_n);

  // Absolute difference and right-hand base
  always_comb begin
    hh     = WW'(e4_h);
    diff_c = (e4_sv >= hh) ? (e4_sv - hh) : (hh - e4_sv);
    rhsa_c = (hh << 2) + e4_nv;
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
      e4_v <= 1'b0;
      e5_v <= 1'b0;
      e6_v <= 1'b0;
    end else begin
      e1_v <= start;
      e2_v <= e1_v;
      e3_v <= e2_v;
      e4_v <= e3_v;
      e5_v <= e4_v;
      e6_v <= e5_v;
    end
  end

  // Advance stage payload
  always_ff @(posedge clk) begin
    e1_sums <= sums_pad;
    e1_s    <= frame_sum;
    e1_n    <= frame_count;
    e1_meta <= meta;

    e2_gsum <= gsum_c;
    e2_gcnt <= gcnt_c;
    e2_s    <= e1_s;
    e2_n    <= e1_n;
    e2_meta <= e1_meta;

    e3_h     <= h_c;
    e3_v_cnt <= v_c;
    e3_s     <= e2_s;
    e3_n     <= e2_n;
    e3_meta  <= e2_meta;

    e4_sv   <= s_ext * e3_v_cnt;
    e4_nv   <= n_ext * e3_v_cnt;
    e4_h    <= e3_h;
    e4_meta <= e3_meta;

    e5_diff <= diff_c;
    e5_rhsa <= rhsa_c;
    e5_meta <= e4_meta;

    e6_lhs  <= LW'(e5_diff) * LW'(SCALE_X4);
    e6_rhs  <= LW'(e5_rhsa) * LW'(e5_meta.permille);
    e6_meta <= e5_meta;
  end

  // Final compare and result word
  assign res_valid = e6_v;
  assign res = '{
    passed:    e6_meta.passed,
    valid_out: e6_meta.valid_in | (e6_meta.amp & (e6_lhs > e6_rhs)),
    processed: e6_meta.processed,
    passed_n:  e6_meta.passed_n,
    filtered:  e6_meta.filtered
  };

endmodule

FILE: hdl/csi_rssi_amplitude_history_filter.sv
// Top level of the RSSI gate and amplitude-history filter.
// Depends on crahf_pkg, crahf_ram and crahf_change.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid / in_ready  | amplitude, amplitude_present, rssi, valid_in, last
//   out     | out_valid/ out_ready | passed, valid_out, processed/passed/filtered_count
//   cfg     | cfg_write            | cfg_index, cfg_data
//
// One input word per cycle while in_ready is high; each costs one read-modify-write
// of one history memory word (all rows of one subcarrier), forwarded when
// back-to-back frames touch the same word. out_valid rises once a frame's last
// word has passed the memory stage, the deviation test pipeline and the result queue.
// in_ready drops only when 16 results are queued or in flight.
// Reset is synchronous; history starts as zero through per-word valid bits,
// so no clearing pass is needed.
module csi_rssi_amplitude_history_filter #(
  parameter int SUBCARRIERS    = crahf_pkg::SUBCARRIERS_DEF,
  parameter int HISTORY_ROWS   = crahf_pkg::HISTORY_ROWS_DEF,
  parameter int AMPLITUDE_BITS = crahf_pkg::AMPLITUDE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [crahf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [crahf_pkg::PERMILLE_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [AMPLITUDE_BITS-1:0]             amplitude,
  input  logic                                  amplitude_present,
  input  logic signed [crahf_pkg::RSSI_W-1:0]   rssi,
  input  logic                                  valid_in,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  passed,
  output logic                                  valid_out,
  output logic [crahf_pkg::COUNT_W-1:0]         processed_count,
  output logic [crahf_pkg::COUNT_W-1:0]         passed_count,
  output logic [crahf_pkg::COUNT_W-1:0]         filtered_count
);
  import crahf_pkg::*;

  localparam int AW     = (SUBCARRIERS > 1) ? $clog2(SUBCARRIERS) : 1;
  localparam int RIW    = (HISTORY_ROWS > 1) ? $clog2(HISTORY_ROWS) : 1;
  localparam int RSW    = AMPLITUDE_BITS + $clog2(SUBCARRIERS);
  localparam int SW     = AMPLITUDE_BITS + ITEM_W;
  localparam int WORD_W = HISTORY_ROWS * AMPLITUDE_BITS;
  localparam int FAW    = $clog2(RESULT_FIFO_DEPTH);
  localparam int FCW    = FAW + 1;
  localparam int GATE_W = RSSI_W + 5;

  // Configuration
  logic [PERMILLE_W-1:0] threshold;
  logic                  amp_enable;

  // Frame state
  logic [ITEM_W-1:0]     item_count;
  logic [SW-1:0]         frame_sum;
  logic                  frame_rejected;
  logic                  frame_has_amp;
  logic [PERMILLE_W-1:0] frame_p;
  logic [RIW-1:0]        row_index;
  logic [COUNT_W-1:0]    processed_total, passed_total, filtered_total;
  logic [RSW-1:0]        row_sums [HISTORY_ROWS];
  logic [SUBCARRIERS-1:0] hist_valid;

  // Accept stage
  logic                  acc, first, in_range, in_row, mem_go;
  logic [PERMILLE_W-1:0] p_eff, p_now;
  logic [GATE_W-1:0]     rssi_x, rssi_x10, gate_sum;
  logic                  rej_first, rej_now, amp_now;
  logic [SW-1:0]         sum_now;
  logic [ITEM_W-1:0]     n_now;
  logic [COUNT_W-1:0]    proc_next, pass_next, filt_next;
  logic [AW-1:0]         rd_addr;

  // Memory stage
  logic                  s1_active, s1_last, s1_first, s1_vbit;
  logic [AW-1:0]         s1_addr;
  logic [RIW-1:0]        s1_row;
  logic [AMPLITUDE_BITS-1:0] s1_amp;
  logic [SW-1:0]         s1_s;
  logic [ITEM_W-1:0]     s1_n;
  frame_meta_t           s1_meta;
  logic [WORD_W-1:0]     rd_word, base_word, merge_word;
  logic                  fwd_hit;
  logic                  wr_q_en;
  logic [AW-1:0]         wr_q_addr;
  logic [WORD_W-1:0]     wr_q_data;
  logic [RSW-1:0]        rs_next [HISTORY_ROWS];
  logic [RSW-1:0]        sums_now [HISTORY_ROWS];

  // Result queue
  logic                  res_valid;
  result_t               res;
  result_t               fifo_mem [RESULT_FIFO_DEPTH];
  logic [FAW-1:0]        wptr, rptr;
  logic [FCW-1:0]        fifo_cnt, used;
  logic                  pop;

  assign acc     = in_valid && in_ready;
  assign rd_addr = item_count[AW-1:0];

  // Gate, frame flags and running sums for the word on the input
  always_comb begin
    first     = (item_count == '0);
    p_eff     = (threshold > PERMILLE_MAX) ? PERMILLE_MAX : threshold;
    rssi_x    = {{(GATE_W-RSSI_W){rssi[RSSI_W-1]}}, rssi};
    rssi_x10  = (rssi_x << 3) + (rssi_x << 1);
    // rssi < -(p div 10) holds exactly when 10*rssi + p < 0
    gate_sum  = rssi_x10 + GATE_W'(p_eff);
    rej_first = gate_sum[GATE_W-1];
    rej_now   = first ? rej_first : frame_rejected;
    amp_now   = first ? (!rej_first && amplitude_present && amp_enable) : frame_has_amp;
    p_now     = first ? p_eff : frame_p;
    in_range  = (item_count != ITEM_MAX);
    in_row    = (item_count < ITEM_W'(SUBCARRIERS));
    mem_go    = acc && amp_now && in_range && in_row;
    sum_now   = (first ? '0 : frame_sum) +
                ((amp_now && in_range) ? SW'(amplitude) : '0);
    n_now     = in_range ? ITEM_W'({1'b0, item_count} + 17'd1) : item_count;
    proc_next = processed_total + 1'b1;
    pass_next = passed_total + (rej_now ? 1'b0 : 1'b1);
    filt_next = filtered_total + (rej_now ? 1'b1 : 1'b0);
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= '0;
      amp_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD:  threshold  <= cfg_data;
        REG_AMP_ENABLE: amp_enable <= cfg_data[0];
      endcase
    end
  end

  // Advance frame state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count      <= '0;
      frame_sum       <= '0;
      frame_rejected  <= 1'b0;
      frame_has_amp   <= 1'b0;
      row_index       <= '0;
      processed_total <= '0;
      passed_total    <= '0;
      filtered_total  <= '0;
    end else if (acc) begin
      if (first) begin
        frame_rejected <= rej_first;
        frame_has_amp  <= amp_now;
      end
      frame_sum  <= sum_now;
      item_count <= last ? '0 : n_now;
      if (last) begin
        processed_total <= proc_next;
        passed_total    <= pass_next;
        filtered_total  <= filt_next;
        row_index       <= (row_index == RIW'(HISTORY_ROWS - 1)) ? '0 : row_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && first) begin
      frame_p <= p_eff;
    end
  end

  // History memory: one word per subcarrier, one lane per row
  crahf_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SUBCARRIERS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (s1_active),
    .wr_addr (s1_addr),
    .wr_data (merge_word),
    .rd_en   (mem_go),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // Register the word into the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_active <= 1'b0;
      s1_last   <= 1'b0;
    end else begin
      s1_active <= mem_go;
      s1_last   <= acc && last;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= rd_addr;
    s1_row   <= row_index;
    s1_amp   <= amplitude;
    s1_first <= first;
    s1_vbit  <= hist_valid[rd_addr];
    s1_s     <= sum_now;
    s1_n     <= n_now;
    s1_meta  <= '{
      amp:       amp_now,
      permille:  p_now,
      passed:    !rej_now,
      valid_in:  valid_in,
      processed: proc_next,
      passed_n:  pass_next,
      filtered:  filt_next
    };
  end

  // Merge: forward last cycle's write, unwritten words read as zero
  always_comb begin
    fwd_hit    = wr_q_en && (wr_q_addr == s1_addr);
    base_word  = fwd_hit ? wr_q_data : (s1_vbit ? rd_word : '0);
    merge_word = base_word;
    merge_word[s1_row*AMPLITUDE_BITS +: AMPLITUDE_BITS] = s1_amp;
    for (int h = 0; h < HISTORY_ROWS; h++) begin
      rs_next[h]  = (s1_first ? '0 : row_sums[h]) +
                    RSW'(base_word[h*AMPLITUDE_BITS +: AMPLITUDE_BITS]);
      sums_now[h] = s1_active ? rs_next[h] : row_sums[h];
    end
  end

  // Accumulate row sums, mark written words, hold the write for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q_en    <= 1'b0;
      hist_valid <= '0;
      for (int h = 0; h < HISTORY_ROWS; h++) begin
        row_sums[h] <= '0;
      end
    end else begin
      wr_q_en <= s1_active;
      if (s1_active) begin
        hist_valid[s1_addr] <= 1'b1;
        row_sums            <= rs_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_q_addr <= s1_addr;
    wr_q_data <= merge_word;
  end

  // Deviation test pipeline
  crahf_change #(
    .SUBCARRIERS    (SUBCARRIERS),
    .HISTORY_ROWS   (HISTORY_ROWS),
    .AMPLITUDE_BITS (AMPLITUDE_BITS)
  ) u_change (
    .clk         (clk),
    .rst         (rst),
    .start       (s1_last),
    .sums        (sums_now),
    .frame_sum   (s1_s),
    .frame_count (s1_n),
    .meta        (s1_meta),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result queue and in-flight credit
  assign pop       = out_valid && out_ready;
  assign out_valid = (fifo_cnt != '0);
  assign in_ready  = (used < FCW'(RESULT_FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr     <= '0;
      rptr     <= '0;
      fifo_cnt <= '0;
      used     <= '0;
    end else begin
      if (res_valid) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      fifo_cnt <= fifo_cnt + FCW'(res_valid) - FCW'(pop);
      used     <= used + FCW'(acc && last) - FCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wptr] <= res;
    end
  end

  // Drive the output word from the queue head
  assign passed          = fifo_mem[rptr].passed;
  assign valid_out       = fifo_mem[rptr].valid_out;
  assign processed_count = fifo_mem[rptr].processed;
  assign passed_count    = fifo_mem[rptr].passed_n;
  assign filtered_count  = fifo_mem[rptr].filtered;

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    used <= FCW'(RESULT_FIFO_DEPTH))
    else $error("in-flight result count exceeds queue depth");

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (used > fifo_cnt))
    else $error("result pushed without an outstanding frame");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    s1_active |-> (int'(s1_addr) < SUBCARRIERS))
    else $error("history write beyond subcarrier count");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_index <= RIW'(HISTORY_ROWS - 1))
    else $error("history row index out of range");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for csi_rssi_amplitude_history_filter: drives subcarrier words, tracks the
// RSSI gate and history comparison itself, and checks every frame verdict word.
// Depends on crahf_pkg and the RTL of the block.
module tb;
  import crahf_pkg::*;

  localparam int NSUB         = SUBCARRIERS_DEF;
  localparam int NROWS        = HISTORY_ROWS_DEF;
  localparam int AMP_W        = AMPLITUDE_BITS_DEF;
  localparam int WORD_LIMIT   = 65535;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_WORDS = 900;

  typedef enum int {RX_OPEN, RX_BUSY_LITTLE, RX_BUSY_MOSTLY, RX_ALTERNATE} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [PERMILLE_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [AMP_W-1:0]       amplitude = '0;
  logic                   amplitude_present = 1'b0;
  logic signed [RSSI_W-1:0] rssi = '0;
  logic                   valid_in = 1'b0;
  logic                   last = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   passed;
  logic                   valid_out;
  logic [COUNT_W-1:0]     processed_count;
  logic [COUNT_W-1:0]     passed_count;
  logic [COUNT_W-1:0]     filtered_count;

  // Tracked copy of the block's configuration and state
  logic [PERMILLE_W-1:0]  cfg_permille = '0;
  bit                     cfg_amp_en = 1'b0;
  logic [AMP_W-1:0]       hist [NROWS][NSUB];
  int unsigned            row_ptr = 0;
  int unsigned            word_cnt = 0;
  longint unsigned        amp_sum = 0;
  longint unsigned        row_acc [NROWS];
  bit                     frame_fail = 1'b0;
  bit                     frame_amp = 1'b0;
  logic [COUNT_W-1:0]     n_processed = '0;
  logic [COUNT_W-1:0]     n_passed = '0;
  logic [COUNT_W-1:0]     n_filtered = '0;

  result_t                pending_verdicts [$];
  result_t                want;
  int                     fail_count = 0;

  // Sender burst state and per-subcarrier amplitude levels
  int                     burst_left = 0;
  int                     level [NSUB];

  // Receiver stall state
  rx_mode_t               rx_mode = RX_OPEN;
  int                     mode_left = 0;
  int                     hold_left = 0;
  int                     stall_requests = 0;
  int                     stall_served = 0;

  csi_rssi_amplitude_history_filter #(
    .SUBCARRIERS    (NSUB),
    .HISTORY_ROWS   (NROWS),
    .AMPLITUDE_BITS (AMP_W)
  ) uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .amplitude         (amplitude),
    .amplitude_present (amplitude_present),
    .rssi              (rssi),
    .valid_in          (valid_in),
    .last              (last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .passed            (passed),
    .valid_out         (valid_out),
    .processed_count   (processed_count),
    .passed_count      (passed_count),
    .filtered_count    (filtered_count)
  );

  always #4 clk = ~clk;

  initial begin
    foreach (hist[r, s]) hist[r][s] = '0;
    foreach (row_acc[r]) row_acc[r] = 0;
  end

  function automatic int clamped_permille();
    return (cfg_permille > PERMILLE_MAX) ? int'(PERMILLE_MAX) : int'(cfg_permille);
  endfunction

  // Compare the frame sum against the mean of the nonzero history rows
  function automatic bit level_shift_seen();
    longint unsigned h_total, v, sv, diff, lhs, rhs;
    h_total = 0;
    v = 0;
    foreach (row_acc[h]) begin
      if (row_acc[h] != 0) begin
        h_total += row_acc[h];
        v++;
      end
    end
    if (v == 0) return 1'b0;
    sv = amp_sum * v;
    diff = (sv >= h_total) ? sv - h_total : h_total - sv;
    lhs = 64'd4000 * diff;
    rhs = longint'(clamped_permille()) * (4 * h_total + longint'(word_cnt) * v);
    return lhs > rhs;
  endfunction

  // Advance the tracked state by one accepted word; queue a verdict on the last word
  task automatic score_word(input logic [AMP_W-1:0] amp, input logic present,
                            input logic signed [RSSI_W-1:0] rssi_v, input logic vin,
                            input logic lst);
    int limit;
    int rssi_i;
    result_t verdict;
    bit shift;
    if (word_cnt == 0) begin
      limit = -(clamped_permille() / 10);
      rssi_i = rssi_v;
      frame_fail = rssi_i < limit;
      frame_amp = !frame_fail && present && cfg_amp_en;
      amp_sum = 0;
      foreach (row_acc[h]) row_acc[h] = 0;
    end
    if (word_cnt < WORD_LIMIT) begin
      if (frame_amp) begin
        amp_sum += amp;
        if (word_cnt < NSUB) begin
          foreach (row_acc[h]) row_acc[h] += hist[h][word_cnt];
          hist[row_ptr][word_cnt] = amp;
        end
      end
      word_cnt++;
    end
    if (lst) begin
      shift = frame_amp ? level_shift_seen() : 1'b0;
      n_processed++;
      if (frame_fail) n_filtered++;
      else n_passed++;
      verdict.passed = !frame_fail;
      verdict.valid_out = vin | shift;
      verdict.processed = n_processed;
      verdict.passed_n = n_passed;
      verdict.filtered = n_filtered;
      pending_verdicts.push_back(verdict);
      row_ptr = (row_ptr + 1) % NROWS;
      word_cnt = 0;
    end
  endtask

  // Offer one word, with bursts and gaps; called and returns at a falling edge
  task automatic send_word(input logic [AMP_W-1:0] amp, input logic present,
                           input logic signed [RSSI_W-1:0] rssi_v, input logic vin,
                           input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    amplitude = amp;
    amplitude_present = present;
    rssi = rssi_v;
    valid_in = vin;
    last = lst;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    score_word(amp, present, rssi_v, vin, lst);
    @(negedge clk);
  endtask

  // Send one frame; gain is in quarters of the stored levels, a negative gain means random
  task automatic send_frame(input int len, input int gain, input int noise,
                            input logic present, input logic signed [RSSI_W-1:0] rssi_v,
                            input logic vin);
    int amp_i;
    logic [AMP_W-1:0] amp_v;
    for (int i = 0; i < len; i++) begin
      if (gain < 0) amp_i = $urandom;
      else amp_i = level[i % NSUB] * gain / 4 + $urandom_range(0, noise);
      amp_v = amp_i[AMP_W-1:0];
      // Later words carry random present and rssi bits that must be ignored; only the last word's valid bit counts
      if (i == 0 && len == 1) send_word(amp_v, present, rssi_v, vin, 1'b1);
      else if (i == 0) send_word(amp_v, present, rssi_v, $urandom, 1'b0);
      else if (i == len - 1) send_word(amp_v, $urandom, $urandom, vin, 1'b1);
      else send_word(amp_v, $urandom, $urandom, $urandom, 1'b0);
    end
  endtask

  task automatic new_levels();
    foreach (level[s]) begin
      case ($urandom_range(0, 9))
        0: level[s] = 0;
        1: level[s] = 32767;
        default: level[s] = $urandom_range(0, 16383);
      endcase
    end
  endtask

  // Drop valid and wait until every verdict has arrived and the pipeline is empty
  task automatic settle();
    in_valid = 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
    settle();
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data = value[PERMILLE_W-1:0];
    if (index == REG_THRESHOLD) cfg_permille = value[PERMILLE_W-1:0];
    else cfg_amp_en = value[0];
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Reset values: threshold zero, amplitude path off
  task automatic test_reset_state();
    send_word(16'hFFFF, 1'b1, 8'sd0, 1'b0, 1'b1);
    send_word(16'h0000, 1'b1, -8'sd1, 1'b1, 1'b1);
    send_word(16'h5A5A, 1'b0, 8'sd127, 1'b1, 1'b1);
    send_word(16'hA5A5, 1'b1, -8'sd128, 1'b0, 1'b1);
  endtask

  // RSSI limit at the edges of the threshold range, including values above 1000
  task automatic test_rssi_gate();
    write_reg(REG_AMP_ENABLE, 0);
    write_reg(REG_THRESHOLD, 1000);
    send_word(16'h0001, 1'b0, -8'sd100, 1'b0, 1'b1);
    send_word(16'h0002, 1'b0, -8'sd101, 1'b0, 1'b1);
    write_reg(REG_THRESHOLD, 1023);
    send_word(16'h0003, 1'b0, -8'sd100, 1'b1, 1'b1);
    send_word(16'h0004, 1'b0, -8'sd101, 1'b1, 1'b1);
    write_reg(REG_THRESHOLD, 9);
    send_word(16'h0005, 1'b1, 8'sd0, 1'b0, 1'b1);
    send_word(16'h0006, 1'b1, -8'sd1, 1'b0, 1'b1);
    write_reg(REG_THRESHOLD, 10);
    send_word(16'h0007, 1'b1, -8'sd1, 1'b0, 1'b1);
    send_word(16'h0008, 1'b1, -8'sd2, 1'b0, 1'b1);
  endtask

  // History comparison: empty history, equal frame, large change, inactive and rejected
  task automatic test_history_compare();
    foreach (level[s]) level[s] = 256 * (s + 1);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_AMP_ENABLE, 1);
    send_frame(3, 4, 0, 1'b1, 8'sd0, 1'b0);
    send_frame(3, 4, 0, 1'b1, 8'sd0, 1'b0);
    send_frame(3, 8, 0, 1'b1, 8'sd5, 1'b0);
    send_frame(3, 8, 0, 1'b0, 8'sd0, 1'b1);
    send_frame(3, 2, 0, 1'b1, -8'sd1, 1'b0);
    send_word(16'hFFFF, 1'b1, 8'sd0, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, -8'sd128, 1'b0, 1'b1);
    write_reg(REG_THRESHOLD, 1000);
    send_frame(3, 5, 0, 1'b1, -8'sd100, 1'b0);
    send_frame(3, 0, 0, 1'b1, 8'sd0, 1'b0);
    write_reg(REG_THRESHOLD, 200);
    send_frame(3, 8, 3, 1'b1, 8'sd0, 1'b0);
  endtask

  // Frames past the subcarrier count
  task automatic test_long_frames();
    new_levels();
    write_reg(REG_THRESHOLD, 100);
    write_reg(REG_AMP_ENABLE, 1);
    send_frame(NSUB + 6, 4, 3, 1'b1, 8'sd0, 1'b0);
    send_frame(NSUB + 6, 5, 3, 1'b1, 8'sd0, 1'b0);
    send_frame(NSUB, 4, 3, 1'b1, 8'sd0, 1'b0);
  endtask

  // Hold the receiver off so the result queue fills and input stalls
  task automatic test_backpressure();
    write_reg(REG_THRESHOLD, 50);
    stall_requests++;
    for (int i = 0; i < 40; i++) send_frame(1, -1, 0, $urandom, $urandom, $urandom);
  endtask

  // Phases of random settings, each a run of frames over a shared level profile
  task automatic test_random_traffic();
    int sent, phase_words, done, p, limit, base_len, len, gain, noise, pick;
    logic signed [RSSI_W-1:0] r_v;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 4))
        0: p = 0;
        1: p = 1000;
        2: p = 1023;
        3: p = $urandom_range(0, 1023);
        default: p = $urandom_range(20, 300);
      endcase
      write_reg(REG_THRESHOLD, p);
      write_reg(REG_AMP_ENABLE, ($urandom_range(0, 4) != 0) ? 1 : 0);
      limit = -(((p > 1000) ? 1000 : p) / 10);
      new_levels();
      case ($urandom_range(0, 3))
        0: base_len = 1;
        1: base_len = $urandom_range(2, 12);
        2: base_len = NSUB;
        default: base_len = $urandom_range(13, 40);
      endcase
      phase_words = $urandom_range(60, 140);
      done = 0;
      while (done < phase_words) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NSUB + 8) : base_len;
        noise = 3;
        case ($urandom_range(0, 7))
          0: gain = 5;
          1: gain = 3;
          2: gain = 8;
          3: gain = 0;
          4: gain = -1;
          5: begin
            gain = 4;
            noise = 0;
          end
          default: gain = 4;
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 14) r_v = 8'($urandom_range(limit + 128, 255) - 128);
        else if (pick < 17) r_v = 8'(limit - $urandom_range(0, 1));
        else r_v = $urandom;
        send_frame(len, gain, noise, $urandom_range(0, 7) != 0, r_v,
                   $urandom_range(0, 3) == 0);
        done += len;
      end
      sent += done;
    end
  endtask

  // Receiver: own stall pattern, plus a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 120);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: out_ready = 1'b1;
        RX_BUSY_LITTLE: out_ready = $urandom_range(0, 3) != 0;
        RX_BUSY_MOSTLY: out_ready = $urandom_range(0, 3) == 0;
        default: out_ready = ~out_ready;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [COUNT_W-1:0] exp_v,
                             input logic [COUNT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Check each accepted verdict word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict word with no frame outstanding");
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("passed", want.passed, passed);
        check_field("valid_out", want.valid_out, valid_out);
        check_field("processed_count", want.processed, processed_count);
        check_field("passed_count", want.passed_n, passed_count);
        check_field("filtered_count", want.filtered, filtered_count);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_rssi_gate();
    test_history_compare();
    test_long_frames();
    test_backpressure();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
